>>> rtl/core/tocsdm_pkg.sv
// shared types, codes and constants of the third-order cifb sigma-delta modulator
package tocsdm_pkg;

    localparam int CoefCount  = 7;
    localparam int CoefWidth  = 16;
    localparam int IntWidth   = 16;
    localparam int SampWidth  = 13;
    localparam int CfgIdxWidth = 3;
    localparam int ProdWidth  = CoefWidth + 1 + IntWidth;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_B1 = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_A1 = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_A2 = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_A3 = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_C1 = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_C2 = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_G1 = 3'd6;

    localparam logic [CoefWidth-1:0] COEF_RESET [CoefCount] = '{
        16'd45147, 16'd45147, 16'd32391, 16'd64202, 16'd57421, 16'd46799, 16'd45588
    };

    // feedback value +/-1 with 14 fractional bits
    localparam logic signed [IntWidth-1:0] FB_POS = 16'sh4000;
    localparam logic signed [IntWidth-1:0] FB_NEG = 16'shC000;

    // product steps in issue order
    typedef enum logic [2:0] {
        OP_B1_U   = 3'd0,
        OP_A1_FB  = 3'd1,
        OP_C1_I1  = 3'd2,
        OP_A2_FB  = 3'd3,
        OP_C2_I2  = 3'd4,
        OP_G1_I3  = 3'd5,
        OP_A3_FB  = 3'd6,
        OP_UNUSED = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_ACC  = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic acc_en;
        op_t  op;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // right shift that brings each product to its integrator format
    function automatic logic [4:0] op_shift(op_t op);
        logic [4:0] s;
        case (op)
            OP_B1_U:  s = 5'd19;
            OP_A1_FB: s = 5'd17;
            OP_C1_I1: s = 5'd18;
            OP_G1_I3: s = 5'd30;
            default:  s = 5'd16;
        endcase
        return s;
    endfunction

    function automatic logic op_sub(op_t op);
        logic r;
        case (op)
            OP_A1_FB, OP_A2_FB, OP_G1_I3, OP_A3_FB: r = 1'b1;
            default:                                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/tocsdm_ctrl.sv
// sequencer of the modulator: steps the shared multiplier through the seven products of an update item
module tocsdm_ctrl
    import tocsdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_update,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_B1_U;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    op_next    = OP_B1_U;
                    state_next = in_update ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (op_reg == OP_A3_FB)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 3'd1);
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tocsdm_datapath.sv
// datapath of the modulator: coefficients, integrators, shared multiplier, output register
module tocsdm_datapath
    import tocsdm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic signed [SampWidth-1:0] sample,
    input  logic                        cfg_wr,
    input  logic [CfgIdxWidth-1:0]      cfg_index,
    input  logic [CoefWidth-1:0]        cfg_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        out_bit
);

    logic [CoefWidth-1:0]        coef_reg [CoefCount];
    logic signed [IntWidth-1:0]  int1_reg, int2_reg, int3_reg;
    logic signed [IntWidth-1:0]  u_reg, acc_reg, acc_next;
    logic signed [ProdWidth-1:0] prod_reg, prod_next, shifted;
    logic                        held_reg, out_valid_reg, out_bit_reg;
    logic [CoefWidth-1:0]        coef_sel;
    logic signed [IntWidth-1:0]  data_sel, fb, base, term;

    assign fb = int3_reg[IntWidth-1] ? FB_NEG : FB_POS;

    always_comb
    begin
        case (cmd.op)
            OP_B1_U:  begin coef_sel = coef_reg[CFG_B1]; data_sel = u_reg;    end
            OP_A1_FB: begin coef_sel = coef_reg[CFG_A1]; data_sel = fb;       end
            OP_C1_I1: begin coef_sel = coef_reg[CFG_C1]; data_sel = int1_reg; end
            OP_A2_FB: begin coef_sel = coef_reg[CFG_A2]; data_sel = fb;       end
            OP_C2_I2: begin coef_sel = coef_reg[CFG_C2]; data_sel = int2_reg; end
            OP_G1_I3: begin coef_sel = coef_reg[CFG_G1]; data_sel = int3_reg; end
            default:  begin coef_sel = coef_reg[CFG_A3]; data_sel = fb;       end
        endcase
    end

    // unsigned coefficient against signed operand
    assign prod_next = $signed({1'b0, coef_sel}) * data_sel;

    // floor to integrator format, then wrap in 16 bits
    assign shifted = prod_reg >>> op_shift(cmd.op);
    assign term    = shifted[IntWidth-1:0];

    always_comb
    begin
        case (cmd.op)
            OP_B1_U:  base = int1_reg;
            OP_C1_I1: base = int2_reg;
            OP_C2_I2: base = int3_reg;
            default:  base = acc_reg;
        endcase
        acc_next = op_sub(cmd.op) ? base - term : base + term;
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            // 16-bit wrap of sample*16
            u_reg <= {sample[IntWidth-5:0], 4'b0000};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CoefCount; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
            int1_reg      <= '0;
            int2_reg      <= '0;
            int3_reg      <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && cfg_index <= CFG_G1)
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
            if (cmd.acc_en)
            begin
                case (cmd.op)
                    OP_A1_FB: int1_reg <= acc_next;
                    OP_A2_FB: int2_reg <= acc_next;
                    OP_A3_FB:
                    begin
                        int3_reg <= acc_next;
                        held_reg <= ~int3_reg[IntWidth-1];
                    end
                    default: ;
                endcase
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                out_bit_reg   <= held_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;

endmodule

>>> rtl/core/third_order_cifb_sigma_delta_modulator.sv
// top level of the third-order cifb sigma-delta modulator
//
// input stream: s_tdata carries the signed 13-bit sample, s_tuser the update flag.
// every input transfer yields exactly one output transfer on m_tdata bit 0: the
// held modulator bit (1 means plus one). with update low the held bit is repeated
// and no state changes; with update high the three integrators advance once.
// coefficients are written over the cfg channel (index 0..6 = b1 a1 a2 a3 c1 c2
// g1, higher indexes ignored); cfg_ready is always high, write only while idle.
//
// sequence: one shared 17x16 multiplier does the seven products, each in a
// multiply state and an accumulate state. an update item passes through the
// accept state, the 14 product/accumulate states and the output load; a hold
// item goes from the accept state straight to the output load. the block
// takes no new input before it is back in idle.
// the result sits in an output register: a stalled receiver only holds the
// block in its output-load state until the register frees, nothing is lost.
// reset (rst_n low, asynchronous) clears the integrators and the held bit,
// restores the coefficient reset values and empties the output register.
module third_order_cifb_sigma_delta_modulator
    import tocsdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] sample, [15:13] zero
    input  logic        s_tuser,   // [0] update
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] pdm_bit, [7:1] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     out_bit;

    // coefficient writes are always taken
    assign cfg_ready = 1'b1;

    tocsdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_update (s_tuser),
        .in_ready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tocsdm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (s_tdata[SampWidth-1:0]),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_bit   (out_bit)
    );

    // only bit 0 carries the result
    assign m_tdata = {7'b0000000, out_bit};

endmodule

>>> rtl/core/tocsdm_checker.sv
// port-level checks of the modulator, bound to the top level
module tocsdm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // pad bits of the result are zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("output pad bits not zero");

    // one item at a time: busy after each input transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transfer");

endmodule

bind third_order_cifb_sigma_delta_modulator tocsdm_checker u_tocsdm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
